// ===== rtl/erm_pkg.sv =====
// Package with shared constants, arctangent table and fixed-point helpers.
package erm_pkg;

    localparam int ANGLE_W  = 16;
    localparam int ENTRY_W  = 16;
    localparam int Z_W      = 34;
    localparam int XY_W     = 33;
    localparam int Q24_W    = 27;
    localparam int ITERS    = 26;

    localparam logic signed [Z_W-1:0]  HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [Z_W-1:0]  PI_Q30      = 34'sd3373259426;
    localparam logic signed [XY_W-1:0] GAIN_Q30    = 33'sd652032874;
    localparam logic signed [ENTRY_W-1:0] ONE_Q14  = 16'sd16384;

    function automatic logic signed [Z_W-1:0] atan_step(input logic [4:0] i);
        logic signed [Z_W-1:0] r;
        begin
            case (i)
                5'd0: r = 34'sd843314856;
                5'd1: r = 34'sd497837829;
                5'd2: r = 34'sd263043836;
                5'd3: r = 34'sd133525158;
                5'd4: r = 34'sd67021686;
                5'd5: r = 34'sd33543515;
                5'd6: r = 34'sd16775850;
                5'd7: r = 34'sd8388437;
                5'd8: r = 34'sd4194282;
                5'd9: r = 34'sd2097149;
                default: r = (34'sd1 <<< (6'd30 - {1'b0, i})) - 34'sd1;
            endcase
            return r;
        end
    endfunction

    typedef struct packed {
        logic signed [Q24_W-1:0] c;
        logic signed [Q24_W-1:0] s;
    } sc_t;

    typedef struct packed {
        logic signed [Q24_W-1:0] w;
        logic signed [Q24_W-1:0] x;
        logic signed [Q24_W-1:0] y;
        logic signed [Q24_W-1:0] z;
    } quat_t;

    typedef struct packed {
        logic signed [ENTRY_W-1:0] r00;
        logic signed [ENTRY_W-1:0] r01;
        logic signed [ENTRY_W-1:0] r02;
        logic signed [ENTRY_W-1:0] r10;
        logic signed [ENTRY_W-1:0] r11;
        logic signed [ENTRY_W-1:0] r12;
        logic signed [ENTRY_W-1:0] r20;
        logic signed [ENTRY_W-1:0] r21;
        logic signed [ENTRY_W-1:0] r22;
    } mat_t;

    function automatic logic signed [ENTRY_W-1:0] to_entry(input logic signed [63:0] v);
        logic signed [63:0] r;
        begin
            r = (v + (64'sd1 <<< 33)) >>> 34;
            if (r > 64'sd16384) r = 64'sd16384;
            if (r < -64'sd16384) r = -64'sd16384;
            return r[ENTRY_W-1:0];
        end
    endfunction

endpackage

// ===== rtl/erm_if.sv =====
// Valid/ready stream interface carrying a generic payload.
interface erm_if #(parameter int W = 48) (input logic clk);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/erm_cordic.sv =====
// Pipelined CORDIC giving cosine and sine of half of one angle.
module erm_cordic (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [erm_pkg::ANGLE_W-1:0]  angle,
    output erm_pkg::sc_t                        sc
);
    localparam int N = erm_pkg::ITERS;

    logic signed [erm_pkg::XY_W-1:0] x_reg [0:N];
    logic signed [erm_pkg::XY_W-1:0] y_reg [0:N];
    logic signed [erm_pkg::Z_W-1:0]  z_reg [0:N];
    logic                            f_reg [0:N];
    logic signed [erm_pkg::Z_W-1:0]  z0;
    logic signed [erm_pkg::XY_W:0]   xr;
    logic signed [erm_pkg::XY_W:0]   yr;
    erm_pkg::sc_t                    sc_next;
    erm_pkg::sc_t                    sc_reg;

    assign z0 = erm_pkg::Z_W'(angle) <<< 16;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= erm_pkg::GAIN_Q30;
            y_reg[0] <= '0;
            if (z0 > erm_pkg::HALF_PI_Q30)
            begin
                z_reg[0] <= z0 - erm_pkg::PI_Q30;
                f_reg[0] <= 1'b1;
            end
            else if (z0 < -erm_pkg::HALF_PI_Q30)
            begin
                z_reg[0] <= z0 + erm_pkg::PI_Q30;
                f_reg[0] <= 1'b1;
            end
            else
            begin
                z_reg[0] <= z0;
                f_reg[0] <= 1'b0;
            end
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_iter
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                f_reg[i+1] <= f_reg[i];
                if (z_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - erm_pkg::atan_step(5'(i));
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + erm_pkg::atan_step(5'(i));
                end
            end
        end
    end

    always_comb
    begin
        xr = (34'(x_reg[N]) + 34'sd32) >>> 6;
        yr = (34'(y_reg[N]) + 34'sd32) >>> 6;
        if (f_reg[N])
        begin
            xr = -xr;
            yr = -yr;
        end
        sc_next.c = xr[erm_pkg::Q24_W-1:0];
        sc_next.s = yr[erm_pkg::Q24_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sc_reg <= sc_next;
        end
    end

    assign sc = sc_reg;
endmodule

// ===== rtl/erm_quat.sv =====
// Pipelined quaternion product of the three elementary rotations.
module erm_quat (
    input  logic         clk,
    input  logic         en,
    input  erm_pkg::sc_t qa,
    input  erm_pkg::sc_t qb,
    input  erm_pkg::sc_t qc,
    output erm_pkg::quat_t q
);
    localparam int P = 2 * erm_pkg::Q24_W;

    logic signed [P-1:0]  ab_reg [0:3];
    logic signed [erm_pkg::Q24_W-1:0] cc_reg, sc_reg;
    logic signed [63:0]   t_reg [0:7];
    erm_pkg::quat_t       q_reg;

    function automatic logic signed [erm_pkg::Q24_W-1:0] rnd(input logic signed [P-1:0] v);
        logic signed [P-1:0] r;
        begin
            r = (v + (P'(1) <<< 23)) >>> 24;
            return r[erm_pkg::Q24_W-1:0];
        end
    endfunction

    function automatic logic signed [erm_pkg::Q24_W-1:0] rnd48(input logic signed [63:0] v);
        logic signed [63:0] r;
        begin
            r = (v + (64'sd1 <<< 23)) >>> 24;
            return r[erm_pkg::Q24_W-1:0];
        end
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ab_reg[0] <= P'(qa.c) * P'(qb.c);
            ab_reg[1] <= P'(qa.s) * P'(qb.s);
            ab_reg[2] <= P'(qa.s) * P'(qb.c);
            ab_reg[3] <= P'(qa.c) * P'(qb.s);
            cc_reg <= qc.c;
            sc_reg <= qc.s;
            t_reg[0] <= 64'(rnd(ab_reg[0])) * 64'(cc_reg);
            t_reg[1] <= 64'(rnd(ab_reg[1])) * 64'(sc_reg);
            t_reg[2] <= 64'(rnd(ab_reg[2])) * 64'(cc_reg);
            t_reg[3] <= 64'(rnd(ab_reg[3])) * 64'(sc_reg);
            t_reg[4] <= 64'(rnd(ab_reg[3])) * 64'(cc_reg);
            t_reg[5] <= 64'(rnd(ab_reg[2])) * 64'(sc_reg);
            t_reg[6] <= 64'(rnd(ab_reg[1])) * 64'(cc_reg);
            t_reg[7] <= 64'(rnd(ab_reg[0])) * 64'(sc_reg);
            q_reg.w <= rnd48(t_reg[0] - t_reg[1]);
            q_reg.x <= rnd48(t_reg[2] + t_reg[3]);
            q_reg.y <= rnd48(t_reg[4] - t_reg[5]);
            q_reg.z <= rnd48(t_reg[6] + t_reg[7]);
        end
    end

    assign q = q_reg;
endmodule

// ===== rtl/erm_matrix.sv =====
// Pipelined conversion of a unit quaternion into the rotation matrix.
module erm_matrix (
    input  logic           clk,
    input  logic           en,
    input  erm_pkg::quat_t q,
    output erm_pkg::mat_t  m
);
    localparam logic signed [63:0] ONE48 = 64'sd1 <<< 48;

    logic signed [63:0] p_reg [0:8];
    erm_pkg::mat_t      m_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg[0] <= 64'(q.x) * 64'(q.x);
            p_reg[1] <= 64'(q.y) * 64'(q.y);
            p_reg[2] <= 64'(q.z) * 64'(q.z);
            p_reg[3] <= 64'(q.x) * 64'(q.y);
            p_reg[4] <= 64'(q.x) * 64'(q.z);
            p_reg[5] <= 64'(q.y) * 64'(q.z);
            p_reg[6] <= 64'(q.w) * 64'(q.x);
            p_reg[7] <= 64'(q.w) * 64'(q.y);
            p_reg[8] <= 64'(q.w) * 64'(q.z);
            m_reg.r00 <= erm_pkg::to_entry(ONE48 - 2 * (p_reg[1] + p_reg[2]));
            m_reg.r01 <= erm_pkg::to_entry(2 * (p_reg[3] - p_reg[8]));
            m_reg.r02 <= erm_pkg::to_entry(2 * (p_reg[4] + p_reg[7]));
            m_reg.r10 <= erm_pkg::to_entry(2 * (p_reg[3] + p_reg[8]));
            m_reg.r11 <= erm_pkg::to_entry(ONE48 - 2 * (p_reg[0] + p_reg[2]));
            m_reg.r12 <= erm_pkg::to_entry(2 * (p_reg[5] - p_reg[6]));
            m_reg.r20 <= erm_pkg::to_entry(2 * (p_reg[4] - p_reg[7]));
            m_reg.r21 <= erm_pkg::to_entry(2 * (p_reg[5] + p_reg[6]));
            m_reg.r22 <= erm_pkg::to_entry(ONE48 - 2 * (p_reg[0] + p_reg[1]));
        end
    end

    assign m = m_reg;
endmodule

// ===== rtl/euler_angles_to_rotation_matrix.sv =====
// Top level: roll, pitch and yaw angles in, rotation matrix entries out.
// One transfer is accepted per clock cycle while the pipeline advances; each item passes
// through 28 CORDIC stages including range reduction and rounding, three quaternion stages
// and two matrix stages, the last of which is the output register.
// The whole pipeline advances when the output is free or being taken, so a stall on
// the result side holds every stage in place and nothing is lost or repeated.
module euler_angles_to_rotation_matrix (
    input  logic   clk,
    input  logic   rst_n,
    erm_if.sink    in_ch,
    erm_if.source  out_ch
);
    localparam int LAT = erm_pkg::ITERS + 2 + 3 + 2;

    logic          en;
    logic [LAT-1:0] v_reg;
    erm_pkg::sc_t  sx, sy, sz;
    erm_pkg::quat_t q;
    erm_pkg::mat_t m;

    assign en = !v_reg[LAT-1] || out_ch.ready;
    assign in_ch.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[LAT-2:0], in_ch.valid};
        end
    end

    erm_cordic u_cx (.clk(clk), .en(en), .angle(in_ch.data[15:0]),  .sc(sx));
    erm_cordic u_cy (.clk(clk), .en(en), .angle(in_ch.data[31:16]), .sc(sy));
    erm_cordic u_cz (.clk(clk), .en(en), .angle(in_ch.data[47:32]), .sc(sz));

    erm_quat u_quat (.clk(clk), .en(en), .qa(sx), .qb(sy), .qc(sz), .q(q));

    erm_matrix u_mat (.clk(clk), .en(en), .q(q), .m(m));

    assign out_ch.valid = v_reg[LAT-1];
    assign out_ch.data  = m;
endmodule
